### rtl/core/wtem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel torque mixer package
// Shared widths, limits, register indexes and the result record.
// ----------------------------------------------------------------------------
package wtem_pkg;

	localparam int POS_W    = 19;
	localparam int EFF_W    = 17;
	localparam int DRV_W    = 16;
	localparam int POWER_W  = 15;
	localparam int GAIN_W   = 8;
	localparam int SCALE_W  = 30;
	localparam int CFG_W    = 15;

	// endstop threshold and overrange limit
	localparam logic [14:0] LIMIT_15 = 15'h7fff;
	localparam logic [15:0] OVER_LIM = 16'hffff;
	// 0.8 in Q15 against a 2^30 shift: 0.8 * 32768
	localparam logic [14:0] SCALE_K  = 15'd26214;

	// tick flags within mode
	localparam int TICK_TIMER_BIT = 0;
	localparam int TICK_FRAME_BIT = 1;
	localparam logic [1:0] MODE_NONE = 2'b00;

	typedef enum logic [0:0] {
		CFG_POWER_LIMIT = 1'b0,
		CFG_SPRING_GAIN = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic                    drive_valid;
		logic signed [DRV_W-1:0] drive_torque;
		logic                    overrange;
		logic                    effect_clipped;
		logic                    output_limited;
		logic signed [DRV_W-1:0] report_position;
	} result_t;

endpackage

### rtl/core/wtem_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel torque mixer channels
// Tick request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wtem_item_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            mode;
	logic signed [wtem_pkg::POS_W-1:0]     position;
	logic signed [wtem_pkg::EFF_W-1:0]     effect_torque;

	modport source (output valid, output mode, output position, output effect_torque,
		input ready);
	modport sink (input valid, input mode, input position, input effect_torque,
		output ready);
endinterface

interface wtem_result_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  drive_valid;
	logic signed [wtem_pkg::DRV_W-1:0]     drive_torque;
	logic                                  overrange;
	logic                                  effect_clipped;
	logic                                  output_limited;
	logic signed [wtem_pkg::DRV_W-1:0]     report_position;

	modport source (output valid, output drive_valid, output drive_torque,
		output overrange, output effect_clipped, output output_limited,
		output report_position, input ready);
	modport sink (input valid, input drive_valid, input drive_torque,
		input overrange, input effect_clipped, input output_limited,
		input report_position, output ready);
endinterface

### rtl/core/wtem_endstop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Endstop spring
// Spring torque from the stored frame position: excess beyond the end,
// clipped, times the gain, pushing back, clipped again.
// ----------------------------------------------------------------------------
module wtem_endstop (
	input  logic signed [wtem_pkg::POS_W-1:0]  last_position,
	input  logic [wtem_pkg::GAIN_W-1:0]        gain,
	output logic signed [wtem_pkg::DRV_W-1:0]  endstop
);

	logic [wtem_pkg::POS_W-1:0]                  pos_mag;
	logic [wtem_pkg::POS_W-1:0]                  excess;
	logic [14:0]                                 excess_clip;
	logic [14+wtem_pkg::GAIN_W:0]                spring_prod;
	logic [14:0]                                 spring_sat;
	logic                                        beyond;

	always_comb begin
		pos_mag = last_position[wtem_pkg::POS_W-1] ? (~last_position + 1'b1)
			: last_position;
		beyond  = pos_mag > {{(wtem_pkg::POS_W-15){1'b0}}, wtem_pkg::LIMIT_15};
		excess  = pos_mag - {{(wtem_pkg::POS_W-15){1'b0}}, wtem_pkg::LIMIT_15};
		excess_clip = (excess > {{(wtem_pkg::POS_W-15){1'b0}}, wtem_pkg::LIMIT_15})
			? wtem_pkg::LIMIT_15 : excess[14:0];
		spring_prod = excess_clip * gain;
		spring_sat  = (spring_prod > {{wtem_pkg::GAIN_W{1'b0}}, wtem_pkg::LIMIT_15})
			? wtem_pkg::LIMIT_15 : spring_prod[14:0];
		if (!beyond) begin
			endstop = '0;
		end else if (last_position[wtem_pkg::POS_W-1]) begin
			endstop = $signed({1'b0, spring_sat});
		end else begin
			endstop = -$signed({1'b0, spring_sat});
		end
	end

endmodule

### rtl/core/wtem_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torque mix
// Effect scaling, endstop sum, power clip, status flags and reported position for one tick.
// ----------------------------------------------------------------------------
module wtem_mix (
	input  logic [1:0]                         mode,
	input  logic signed [wtem_pkg::POS_W-1:0]  position,
	input  logic signed [wtem_pkg::EFF_W-1:0]  effect_torque,
	input  logic signed [wtem_pkg::DRV_W-1:0]  endstop_prev,
	input  logic signed [wtem_pkg::DRV_W-1:0]  endstop_cur,
	input  logic signed [wtem_pkg::POS_W-1:0]  last_position_next,
	input  logic [wtem_pkg::POWER_W-1:0]       power,
	input  logic [wtem_pkg::SCALE_W-1:0]       scale,
	output wtem_pkg::result_t                  res
);

	localparam int SUM_W  = 19;
	localparam int PROD_W = wtem_pkg::EFF_W + wtem_pkg::SCALE_W;

	logic                          frame;
	logic                          do_scale;
	logic [wtem_pkg::EFF_W-1:0]    eff_mag;
	logic [wtem_pkg::POS_W-1:0]    pos_mag;
	logic [PROD_W-1:0]             eff_prod;
	logic [wtem_pkg::EFF_W-1:0]    eff_scaled;
	logic signed [SUM_W-1:0]       torque;
	logic signed [SUM_W-1:0]       sum;
	logic signed [SUM_W-1:0]       pw_pos;
	logic signed [SUM_W-1:0]       pw_neg;
	logic signed [wtem_pkg::DRV_W-1:0] drive;
	logic [wtem_pkg::DRV_W-1:0]    drive_mag;
	logic                          issue;

	always_comb begin
		frame   = mode[wtem_pkg::TICK_FRAME_BIT];
		eff_mag = effect_torque[wtem_pkg::EFF_W-1] ? (~effect_torque + 1'b1)
			: effect_torque;
		pos_mag = position[wtem_pkg::POS_W-1] ? (~position + 1'b1) : position;

		do_scale = frame && ((endstop_cur == '0)
			|| (endstop_cur > 0 && effect_torque > 0)
			|| (endstop_cur < 0 && effect_torque < 0));

		// magnitude product, truncated toward zero by the shift
		eff_prod   = eff_mag * scale;
		eff_scaled = eff_prod[PROD_W-1:30];

		if (!frame) begin
			torque = '0;
		end else if (do_scale) begin
			torque = effect_torque[wtem_pkg::EFF_W-1]
				? -$signed({2'b00, eff_scaled}) : $signed({2'b00, eff_scaled});
		end else begin
			torque = SUM_W'(effect_torque);
		end

		sum    = torque + SUM_W'(endstop_cur);
		pw_pos = $signed({{(SUM_W-wtem_pkg::POWER_W){1'b0}}, power});
		pw_neg = -pw_pos;
		if (sum > pw_pos) begin
			drive = pw_pos[wtem_pkg::DRV_W-1:0];
		end else if (sum < pw_neg) begin
			drive = pw_neg[wtem_pkg::DRV_W-1:0];
		end else begin
			drive = sum[wtem_pkg::DRV_W-1:0];
		end
		drive_mag = drive[wtem_pkg::DRV_W-1] ? (~drive + 1'b1) : drive;

		issue = (endstop_cur != endstop_prev) || do_scale;

		res.drive_valid    = issue;
		res.drive_torque   = issue ? drive : '0;
		res.overrange      = (mode != wtem_pkg::MODE_NONE)
			&& (pos_mag > {{(wtem_pkg::POS_W-16){1'b0}}, wtem_pkg::OVER_LIM});
		res.effect_clipped = frame
			&& (eff_mag >= {{(wtem_pkg::EFF_W-15){1'b0}}, wtem_pkg::LIMIT_15});
		res.output_limited = issue && (drive_mag == {1'b0, power});

		if (last_position_next > $signed({4'b0000, wtem_pkg::LIMIT_15})) begin
			res.report_position = $signed({1'b0, wtem_pkg::LIMIT_15});
		end else if (last_position_next < -$signed({4'b0000, wtem_pkg::LIMIT_15})) begin
			res.report_position = -$signed({1'b0, wtem_pkg::LIMIT_15});
		end else begin
			res.report_position = last_position_next[wtem_pkg::DRV_W-1:0];
		end
	end

endmodule

### rtl/core/wheel_torque_endstop_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel torque endstop mixer
// Mixes the force effect torque with a soft endstop spring, clips the drive
// to the power limit and reports overrange and saturation flags per tick.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  item      in   valid / ready    mode, position, effect_torque
//  result    out  valid / ready    drive_valid, drive_torque, overrange,
//                                  effect_clipped, output_limited, report_position
//  cfg       in   cfg_wen          cfg_index, cfg_wdata (no read-back)
//
//  One request per cycle sustained while results are taken; a request passes
//  through the input register, then the mix logic into the result register.
//  The path between the two is the 17 x 30 bit effect scaling multiply.
//  arst_n clears handshake state, the stored frame position and the endstop
//  torque, and loads power limit = 0, spring gain = 1.
//  A stalled result holds; the input register still drains into it as soon
//  as the result is taken, so ready drops only while both stages are full.
// ----------------------------------------------------------------------------
module wheel_torque_endstop_mixer (
	input  logic                               clk,
	input  logic                               arst_n,
	wtem_item_if.sink                          item,
	wtem_result_if.source                      result,
	input  logic                               cfg_wen,
	input  logic [0:0]                         cfg_index,
	input  logic [wtem_pkg::CFG_W-1:0]         cfg_wdata
);

	// configuration
	logic [wtem_pkg::POWER_W-1:0]              power_q;
	logic [wtem_pkg::GAIN_W-1:0]               gain_q;
	logic [wtem_pkg::SCALE_W-1:0]              scale_q;

	// tick state
	logic signed [wtem_pkg::POS_W-1:0]         last_pos_q;
	logic signed [wtem_pkg::DRV_W-1:0]         endstop_q;

	// input stage
	logic                                      valid_s1;
	logic [1:0]                                mode_s1;
	logic signed [wtem_pkg::POS_W-1:0]         pos_s1;
	logic signed [wtem_pkg::EFF_W-1:0]         eff_s1;

	// result stage
	logic                                      res_valid_q;
	wtem_pkg::result_t                         res_q;

	logic                                      advance;
	logic                                      tick;
	logic signed [wtem_pkg::DRV_W-1:0]         endstop_calc;
	logic signed [wtem_pkg::DRV_W-1:0]         endstop_cur;
	logic signed [wtem_pkg::POS_W-1:0]         last_pos_next;
	wtem_pkg::result_t                         res_next;

	// Move the held request on whenever the result slot is free or emptying.
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	// A tick of either kind refreshes the endstop; a frame tick stores position.
	assign tick          = (mode_s1 != wtem_pkg::MODE_NONE);
	assign endstop_cur   = tick ? endstop_calc : endstop_q;
	assign last_pos_next = mode_s1[wtem_pkg::TICK_FRAME_BIT] ? pos_s1 : last_pos_q;

	// Spring works from the position of the previous frame tick.
	wtem_endstop u_endstop (
		.last_position (last_pos_q),
		.gain          (gain_q),
		.endstop       (endstop_calc)
	);

	wtem_mix u_mix (
		.mode               (mode_s1),
		.position           (pos_s1),
		.effect_torque      (eff_s1),
		.endstop_prev       (endstop_q),
		.endstop_cur        (endstop_cur),
		.last_position_next (last_pos_next),
		.power              (power_q),
		.scale              (scale_q),
		.res                (res_next)
	);

	// Configuration: keep power * 0.8 (Q15) alongside the limit so the tick
	// path needs a single multiply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q <= '0;
			gain_q  <= wtem_pkg::GAIN_W'(1);
			scale_q <= '0;
		end else if (cfg_wen) begin
			if (cfg_index == wtem_pkg::CFG_POWER_LIMIT) begin
				power_q <= cfg_wdata[wtem_pkg::POWER_W-1:0];
				scale_q <= cfg_wdata[wtem_pkg::POWER_W-1:0] * wtem_pkg::SCALE_K;
			end else if (cfg_index == wtem_pkg::CFG_SPRING_GAIN) begin
				gain_q  <= cfg_wdata[wtem_pkg::GAIN_W-1:0];
			end
		end
	end

	// Tick state: commit only when the request leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
			endstop_q  <= '0;
		end else if (advance) begin
			endstop_q  <= endstop_cur;
			last_pos_q <= last_pos_next;
		end
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_s1 <= item.mode;
			pos_s1  <= item.position;
			eff_s1  <= item.effect_torque;
		end
	end

	// Result stage: load on advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.drive_valid     = res_q.drive_valid;
	assign result.drive_torque    = res_q.drive_torque;
	assign result.overrange       = res_q.overrange;
	assign result.effect_clipped  = res_q.effect_clipped;
	assign result.output_limited  = res_q.output_limited;
	assign result.report_position = res_q.report_position;

endmodule
